>>> hw/rtl/fcfl_pkg.sv
// Shared types, codes and helpers for the fixed chunk free list.
`default_nettype none
package fcfl_pkg;

    localparam int MAX_CHUNKS = 256;
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int LINK_W     = IDX_W + 1;
    localparam int CNT_W      = 9;
    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(MAX_CHUNKS);

    localparam logic [1:0] OP_ALLOC    = 2'd0;
    localparam logic [1:0] OP_FREE     = 2'd1;
    localparam logic [1:0] OP_FREE_ALL = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [2:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_RANGE,
        CMD_REBUILD,
        CMD_NOP
    } t_cmd;

    typedef struct packed {
        t_cmd             cmd;
        logic [IDX_W-1:0] idx;
    } t_qword;

    typedef struct packed {
        logic   valid;
        t_qword word;
    } t_qhead;

    typedef struct packed {
        logic reading;
        logic head_empty;
    } t_back_stat;

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_READ = 2'b10
    } t_back_state;

    // Head of a freshly built list for a given chunk count.
    function automatic logic [LINK_W-1:0] full_head(input logic [CNT_W-1:0] count);
        logic [LINK_W-1:0] head;
        if (count == '0) begin
            head = END_MARK;
        end else if (count >= CNT_W'(MAX_CHUNKS)) begin
            head = LINK_W'(MAX_CHUNKS - 1);
        end else begin
            head = LINK_W'(count - CNT_W'(1));
        end
        return head;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fixed_chunk_free_list.sv
// Top level of the fixed chunk free list allocator.
// Each word is queued by the front end and issued when the back end is idle; free,
// free-all and rejected words register a result at issue, allocate after its link read.
// An allocate holds the back end in BK_READ for that read; other words leave it idle.
// Reset and a pool size write rebuild the full list at once with per-entry valid bits.
// Results show for one cycle with o_done; the receiver cannot stall them.
`default_nettype none
module fixed_chunk_free_list (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic [1:0]                   i_opcode,
    input  wire logic [fcfl_pkg::IDX_W-1:0]   i_free_index,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [fcfl_pkg::CNT_W-1:0]   i_cfg_wr_word,
    output logic                              o_done,
    output logic [fcfl_pkg::IDX_W-1:0]        o_granted_index,
    output logic [1:0]                        o_status
);

    fcfl_pkg::t_qhead                 qhead;
    fcfl_pkg::t_back_stat             stat;
    logic [fcfl_pkg::CNT_W-1:0]       pool_size;
    logic                             pop;

    fcfl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_opcode      (i_opcode),
        .i_free_index  (i_free_index),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_word (i_cfg_wr_word),
        .i_pop         (pop),
        .o_qhead       (qhead),
        .o_pool_size   (pool_size),
        .o_busy        (o_busy)
    );

    fcfl_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_qhead         (qhead),
        .i_pool_size     (i_cfg_wr_en ? i_cfg_wr_word : pool_size),
        .i_rebuild       (i_cfg_wr_en),
        .o_pop           (pop),
        .o_stat          (stat),
        .o_done          (o_done),
        .o_granted_index (o_granted_index),
        .o_status        (o_status)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("busy rose without an accepted word");

    a_empty_matches_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == fcfl_pkg::ST_EMPTY)) |-> $past(stat.head_empty))
        else $error("empty status while the list held a chunk");

    a_no_result_while_reading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.reading |-> !o_done)
        else $error("result shown during a link read");

    a_reject_grants_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != fcfl_pkg::ST_OK)) |-> (o_granted_index == '0))
        else $error("rejected word carried a chunk index");

endmodule
`default_nettype wire

>>> hw/rtl/fcfl_front.sv
// Front end: chunk count register, command classification and a two-word queue.
`default_nettype none
module fcfl_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [1:0]                   i_opcode,
    input  wire logic [fcfl_pkg::IDX_W-1:0]   i_free_index,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [fcfl_pkg::CNT_W-1:0]   i_cfg_wr_word,
    input  wire logic                         i_pop,
    output fcfl_pkg::t_qhead                  o_qhead,
    output logic [fcfl_pkg::CNT_W-1:0]        o_pool_size,
    output logic                              o_busy
);

    logic [fcfl_pkg::CNT_W-1:0] r_pool_size;
    fcfl_pkg::t_qword           r_q [2];
    logic                       r_wr_ptr;
    logic                       r_rd_ptr;
    logic [1:0]                 r_cnt;
    logic [1:0]                 n_cnt;
    fcfl_pkg::t_qword           class_word;
    logic                       push;
    logic                       pop;
    logic                       in_range;

    assign push = i_start && !o_busy;
    assign pop  = i_pop && (r_cnt != 2'd0);

    assign in_range = (r_pool_size >= fcfl_pkg::CNT_W'(fcfl_pkg::MAX_CHUNKS))
        || (fcfl_pkg::CNT_W'(i_free_index) < r_pool_size);

    always_comb begin
        class_word.idx = i_free_index;
        unique case (i_opcode)
            fcfl_pkg::OP_ALLOC:    class_word.cmd = fcfl_pkg::CMD_ALLOC;
            fcfl_pkg::OP_FREE:     class_word.cmd = in_range ? fcfl_pkg::CMD_FREE
                                                             : fcfl_pkg::CMD_RANGE;
            fcfl_pkg::OP_FREE_ALL: class_word.cmd = fcfl_pkg::CMD_REBUILD;
            default:               class_word.cmd = fcfl_pkg::CMD_NOP;
        endcase
    end

    always_comb begin
        unique case ({push, pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= fcfl_pkg::CNT_W'(fcfl_pkg::MAX_CHUNKS);
            r_wr_ptr    <= 1'b0;
            r_rd_ptr    <= 1'b0;
            r_cnt       <= 2'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_pool_size <= i_cfg_wr_word;
            end
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= class_word;
        end
    end

    assign o_qhead.valid  = (r_cnt != 2'd0);
    assign o_qhead.word   = r_q[r_rd_ptr];
    assign o_pool_size    = r_pool_size;
    assign o_busy         = (r_cnt == 2'd2);

endmodule
`default_nettype wire

>>> hw/rtl/fcfl_back.sv
// Back end: list head, link memory with valid bits, and result register.
`default_nettype none
module fcfl_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  fcfl_pkg::t_qhead                  i_qhead,
    input  wire logic [fcfl_pkg::CNT_W-1:0]   i_pool_size,
    input  wire logic                         i_rebuild,
    output logic                              o_pop,
    output fcfl_pkg::t_back_stat              o_stat,
    output logic                              o_done,
    output logic [fcfl_pkg::IDX_W-1:0]        o_granted_index,
    output logic [1:0]                        o_status
);

    fcfl_pkg::t_back_state              r_state;
    fcfl_pkg::t_back_state              n_state;
    logic [fcfl_pkg::LINK_W-1:0]        r_head;
    logic [fcfl_pkg::LINK_W-1:0]        n_head;
    logic [fcfl_pkg::MAX_CHUNKS-1:0]    r_valid;
    logic [fcfl_pkg::LINK_W-1:0]        r_mem [fcfl_pkg::MAX_CHUNKS];
    logic [fcfl_pkg::LINK_W-1:0]        r_rd_data;
    logic                               r_rd_valid;
    logic                               r_done;
    logic                               n_done;
    logic [fcfl_pkg::IDX_W-1:0]         r_granted;
    logic [fcfl_pkg::IDX_W-1:0]         n_granted;
    logic [1:0]                         r_status;
    logic [1:0]                         n_status;
    logic                               issue;
    logic                               mem_we;
    logic                               clr_valid;
    logic [fcfl_pkg::IDX_W-1:0]         head_idx;
    logic [fcfl_pkg::LINK_W-1:0]        default_link;

    assign issue    = (r_state == fcfl_pkg::BK_IDLE) && i_qhead.valid;
    assign head_idx = r_head[fcfl_pkg::IDX_W-1:0];
    assign default_link = (head_idx == '0) ? fcfl_pkg::END_MARK
                                           : fcfl_pkg::LINK_W'(head_idx - 1'b1);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_done    = 1'b0;
        n_granted = '0;
        n_status  = fcfl_pkg::ST_OK;
        mem_we    = 1'b0;
        clr_valid = 1'b0;
        unique case (r_state)
            fcfl_pkg::BK_IDLE: begin
                if (issue) begin
                    unique case (i_qhead.word.cmd)
                        fcfl_pkg::CMD_ALLOC: begin
                            if (r_head[fcfl_pkg::IDX_W]) begin
                                n_done   = 1'b1;
                                n_status = fcfl_pkg::ST_EMPTY;
                            end else begin
                                n_state = fcfl_pkg::BK_READ;
                            end
                        end
                        fcfl_pkg::CMD_FREE: begin
                            mem_we = 1'b1;
                            n_head = fcfl_pkg::LINK_W'(i_qhead.word.idx);
                            n_done = 1'b1;
                        end
                        fcfl_pkg::CMD_RANGE: begin
                            n_done   = 1'b1;
                            n_status = fcfl_pkg::ST_RANGE;
                        end
                        fcfl_pkg::CMD_REBUILD: begin
                            clr_valid = 1'b1;
                            n_head    = fcfl_pkg::full_head(i_pool_size);
                            n_done    = 1'b1;
                        end
                        fcfl_pkg::CMD_NOP: begin
                            n_done = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            fcfl_pkg::BK_READ: begin
                n_head    = r_rd_valid ? r_rd_data : default_link;
                n_done    = 1'b1;
                n_granted = head_idx;
                n_state   = fcfl_pkg::BK_IDLE;
            end
            default: begin
                n_state = fcfl_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcfl_pkg::BK_IDLE;
            r_head  <= fcfl_pkg::full_head(fcfl_pkg::CNT_W'(fcfl_pkg::MAX_CHUNKS));
            r_valid <= '0;
            r_done  <= 1'b0;
        end else if (i_rebuild) begin
            r_state <= fcfl_pkg::BK_IDLE;
            r_head  <= fcfl_pkg::full_head(i_pool_size);
            r_valid <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_done  <= n_done;
            if (clr_valid) begin
                r_valid <= '0;
            end else if (mem_we) begin
                r_valid[i_qhead.word.idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_granted  <= n_granted;
        r_status   <= n_status;
        r_rd_valid <= r_valid[head_idx];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_qhead.word.idx] <= r_head;
        end
        r_rd_data <= r_mem[head_idx];
    end

    assign o_pop              = issue;
    assign o_stat.reading     = (r_state == fcfl_pkg::BK_READ);
    assign o_stat.head_empty  = r_head[fcfl_pkg::IDX_W];
    assign o_done             = r_done;
    assign o_granted_index    = r_granted;
    assign o_status           = r_status;

endmodule
`default_nettype wire
